// File: design/etf_pkg.sv
// Shared types and constants for the escape-time fractal iteration block.
package etf_pkg;

    // Field widths
    localparam int PIXEL_COORD_BITS = 12;
    localparam int ITER_BITS        = 12;
    localparam int COORD_W          = 32;
    localparam int STEP_W           = 31;
    localparam int PROD_W           = 2 * COORD_W;
    localparam int FRAC_BITS        = 28;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_REAL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_IMAG  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_STEP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITER_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BURNING_SHIP = 3'd4;

    // Register reset values
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_REAL = -32'sd617401549;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_IMAG = -32'sd483183821;
    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP  = 31'd2684355;
    localparam logic [ITER_BITS-1:0]      RST_ITER_LIMIT  = ITER_BITS'(30);

    // Escape threshold: 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

    // Signed 32-bit limits
    localparam logic signed [COORD_W-1:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] MIN32 = 32'sh8000_0000;

    typedef struct packed {
        logic [PIXEL_COORD_BITS-1:0] pixel_col;
        logic [PIXEL_COORD_BITS-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [ITER_BITS-1:0] iteration_count;
        logic                 escaped;
    } t_result;

endpackage

// File: design/escape_time_fractal_iteration.sv
// Top level: sequencer, configuration registers and iteration state.
//
// Usage: write configuration through i_cfg_we / i_cfg_index / i_cfg_data while
// the block is idle (index 0 origin_real, 1 origin_imag, 2 pixel_step,
// 3 iteration_limit, 4 burning_ship_mode; other indexes are ignored).
// A pixel beat is taken on i_pixel at a clock edge where start is high and
// busy is low. busy stays high until the pixel is finished.
// The result beat appears on o_result for one cycle with o_result_strobe high;
// the receiver cannot stall, so it must take the beat in that cycle. busy is
// already low during the strobe cycle, so the next pixel may start then.
// From the accepting edge, c is formed in states CR, CI and CI2; then each of
// the n iterations performed (n at most iteration_limit) steps through SQR,
// SQI, CHK and UPD, because the single shared 32x32 multiplier forms zr^2,
// zi^2 and zr*zi in turn and UPD applies the update. A final SQR, SQI, CHK
// pass ends the pixel and registers the result beat.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// strobe and loads the configuration registers with their default values.
module escape_time_fractal_iteration (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  etf_pkg::t_pixel                      i_pixel,
    output logic                                 o_result_strobe,
    output etf_pkg::t_result                     o_result,
    input  logic                                 i_cfg_we,
    input  logic [etf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [etf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CR   = 3'd1;
    localparam logic [2:0] ST_CI   = 3'd2;
    localparam logic [2:0] ST_CI2  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_SQI  = 3'd5;
    localparam logic [2:0] ST_CHK  = 3'd6;
    localparam logic [2:0] ST_UPD  = 3'd7;

    function automatic logic signed [etf_pkg::COORD_W-1:0] sat48(
        input logic signed [47:0] v
    );
        if (v > 48'(etf_pkg::MAX32))      sat48 = etf_pkg::MAX32;
        else if (v < 48'(etf_pkg::MIN32)) sat48 = etf_pkg::MIN32;
        else                              sat48 = v[etf_pkg::COORD_W-1:0];
    endfunction

    // Configuration registers
    logic signed [etf_pkg::COORD_W-1:0]   r_origin_real;
    logic signed [etf_pkg::COORD_W-1:0]   r_origin_imag;
    logic [etf_pkg::STEP_W-1:0]           r_pixel_step;
    logic [etf_pkg::ITER_BITS-1:0]        r_limit;
    logic                                 r_burning_ship;

    // Sequencer and iteration state
    logic [2:0]                           r_state, n_state;
    logic [etf_pkg::PIXEL_COORD_BITS-1:0] r_row;
    logic signed [etf_pkg::COORD_W-1:0]   r_c_real, r_c_imag;
    logic signed [etf_pkg::COORD_W-1:0]   r_z_real, r_z_imag;
    logic signed [etf_pkg::PROD_W-1:0]    r_sqr;
    logic signed [39:0]                   r_diff_sh;
    logic [etf_pkg::ITER_BITS-1:0]        r_iter;
    logic                                 r_strobe;
    etf_pkg::t_result                     r_result;

    logic signed [etf_pkg::COORD_W-1:0]   mul_a, mul_b;
    logic signed [etf_pkg::PROD_W-1:0]    prod;
    logic signed [etf_pkg::COORD_W-1:0]   upd_real, upd_imag;
    logic [etf_pkg::PROD_W-1:0]           mag;
    logic signed [etf_pkg::PROD_W-1:0]    diff;
    logic                                 esc;
    logic                                 done;
    logic signed [47:0]                   c_sum;
    logic signed [etf_pkg::COORD_W-1:0]   c_origin;

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_real  <= etf_pkg::RST_ORIGIN_REAL;
            r_origin_imag  <= etf_pkg::RST_ORIGIN_IMAG;
            r_pixel_step   <= etf_pkg::RST_PIXEL_STEP;
            r_limit        <= etf_pkg::RST_ITER_LIMIT;
            r_burning_ship <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                etf_pkg::CFG_ORIGIN_REAL:  r_origin_real  <= i_cfg_data;
                etf_pkg::CFG_ORIGIN_IMAG:  r_origin_imag  <= i_cfg_data;
                etf_pkg::CFG_PIXEL_STEP:   r_pixel_step   <= i_cfg_data[etf_pkg::STEP_W-1:0];
                etf_pkg::CFG_ITER_LIMIT:   r_limit        <= i_cfg_data[etf_pkg::ITER_BITS-1:0];
                etf_pkg::CFG_BURNING_SHIP: r_burning_ship <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Select multiplier operands by step
    always_comb begin
        case (r_state)
            ST_IDLE: begin
                mul_a = signed'(etf_pkg::COORD_W'(i_pixel.pixel_col));
                mul_b = signed'({1'b0, r_pixel_step});
            end
            ST_CR: begin
                mul_a = signed'(etf_pkg::COORD_W'(r_row));
                mul_b = signed'({1'b0, r_pixel_step});
            end
            ST_SQR: begin
                mul_a = r_z_real;
                mul_b = r_z_real;
            end
            ST_SQI: begin
                mul_a = r_z_imag;
                mul_b = r_z_imag;
            end
            default: begin
                mul_a = r_z_real;
                mul_b = r_z_imag;
            end
        endcase
    end

    etf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    etf_upd u_upd (
        .i_diff_sh      (r_diff_sh),
        .i_cross        (prod),
        .i_c_real       (r_c_real),
        .i_c_imag       (r_c_imag),
        .i_burning_ship (r_burning_ship),
        .o_z_real       (upd_real),
        .o_z_imag       (upd_imag)
    );

    // Form c from origin plus scaled index (prod holds col*step, then row*step)
    assign c_origin = (r_state == ST_CR) ? r_origin_real : r_origin_imag;
    assign c_sum    = 48'(c_origin) + prod[47:0];

    // Escape test and difference of squares (prod holds zi^2 in the check step)
    assign mag  = r_sqr + prod;
    assign diff = r_sqr - prod;
    assign esc  = (mag >= etf_pkg::ESCAPE_Q56);
    assign done = esc || (r_iter >= r_limit);

    // Advance the sequencer
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = start ? ST_CR : ST_IDLE;
            ST_CR:   n_state = ST_CI;
            ST_CI:   n_state = ST_CI2;
            ST_CI2:  n_state = ST_SQR;
            ST_SQR:  n_state = ST_SQI;
            ST_SQI:  n_state = ST_CHK;
            ST_CHK:  n_state = done ? ST_IDLE : ST_UPD;
            ST_UPD:  n_state = ST_SQR;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_CHK) && done;
        end
    end

    // Hold iteration datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_row <= i_pixel.pixel_row;
                end
            end
            ST_CR: begin
                r_c_real <= sat48(c_sum);
            end
            ST_CI: begin
                r_c_imag <= sat48(c_sum);
            end
            ST_CI2: begin
                r_z_real <= '0;
                r_z_imag <= '0;
                r_iter   <= '0;
            end
            ST_SQI: begin
                r_sqr <= prod;
            end
            ST_CHK: begin
                r_diff_sh <= 40'(signed'(diff[etf_pkg::PROD_W-1:etf_pkg::FRAC_BITS]));
                r_result.iteration_count <= r_iter;
                r_result.escaped         <= esc;
            end
            ST_UPD: begin
                r_z_real <= upd_real;
                r_z_imag <= upd_imag;
                r_iter   <= r_iter + 1'b1;
            end
            default: ;
        endcase
    end

    // A result beat never reports more iterations than the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_result.iteration_count <= r_limit))
        else $error("iteration count above limit");

    // A non-escaped beat must have run the full limit
    a_full_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_result.escaped) |-> (r_result.iteration_count == r_limit))
        else $error("stopped early without escape");

    // An update only happens below the limit
    a_upd_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_iter < r_limit))
        else $error("update past limit");

    // An accepted pixel makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted pixel not started");

    // The result beat comes with the return to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (!busy && $past(r_state) == ST_CHK))
        else $error("result beat outside finish");

endmodule

// File: design/etf_mul.sv
// Shared signed 32x32 multiplier with registered product.
module etf_mul (
    input  logic                                  i_clk,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_a,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_b,
    output logic signed [etf_pkg::PROD_W-1:0]     o_prod
);

    // Multiply and register every cycle
    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule

// File: design/etf_upd.sv
// Update of z: rescale, add c, saturate, optional absolute value.
module etf_upd (
    input  logic signed [39:0]                    i_diff_sh,
    input  logic signed [etf_pkg::PROD_W-1:0]     i_cross,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_c_real,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_c_imag,
    input  logic                                  i_burning_ship,
    output logic signed [etf_pkg::COORD_W-1:0]    o_z_real,
    output logic signed [etf_pkg::COORD_W-1:0]    o_z_imag
);

    function automatic logic signed [etf_pkg::COORD_W-1:0] sat40(
        input logic signed [39:0] v
    );
        if (v > 40'(etf_pkg::MAX32))      sat40 = etf_pkg::MAX32;
        else if (v < 40'(etf_pkg::MIN32)) sat40 = etf_pkg::MIN32;
        else                              sat40 = v[etf_pkg::COORD_W-1:0];
    endfunction

    function automatic logic signed [etf_pkg::COORD_W-1:0] abs_sat(
        input logic signed [etf_pkg::COORD_W-1:0] v
    );
        if (v == etf_pkg::MIN32) abs_sat = etf_pkg::MAX32;
        else if (v[etf_pkg::COORD_W-1]) abs_sat = -v;
        else abs_sat = v;
    endfunction

    logic signed [39:0]                 cross_sh;
    logic signed [39:0]                 sum_r;
    logic signed [39:0]                 sum_i;
    logic signed [etf_pkg::COORD_W-1:0] sat_r;
    logic signed [etf_pkg::COORD_W-1:0] sat_i;

    // Floor-scale the cross product by 2^27 (doubling folded in)
    assign cross_sh = 40'(i_cross >>> (etf_pkg::FRAC_BITS - 1));

    // Add c and clamp to 32 bits
    assign sum_r = i_diff_sh + 40'(i_c_real);
    assign sum_i = cross_sh + 40'(i_c_imag);
    assign sat_r = sat40(sum_r);
    assign sat_i = sat40(sum_i);

    // Fold both parts into the positive quadrant in burning-ship mode
    assign o_z_real = i_burning_ship ? abs_sat(sat_r) : sat_r;
    assign o_z_imag = i_burning_ship ? abs_sat(sat_i) : sat_i;

endmodule

// File: bench/tb_escape_time_fractal_iteration.sv
`timescale 1ns / 1ps
// Self-checking bench for the escape-time iteration block: directed table, random views, predictor.
module tb_escape_time_fractal_iteration;

    // View of the complex plane as held by the configuration registers
    typedef struct packed {
        logic signed [etf_pkg::COORD_W-1:0] origin_r;
        logic signed [etf_pkg::COORD_W-1:0] origin_i;
        logic [etf_pkg::STEP_W-1:0]         step;
        logic [etf_pkg::ITER_BITS-1:0]      limit;
        logic                               ship;
    } t_view_cfg;

    // One row of the directed table
    typedef struct packed {
        t_view_cfg        view;
        etf_pkg::t_pixel  px;
        logic             typed;
        etf_pkg::t_result want;
    } t_pixel_case;

    localparam logic [etf_pkg::CFG_INDEX_W-1:0] CFG_FIRST_UNUSED =
        etf_pkg::CFG_BURNING_SHIP + 3'd1;
    localparam int N_DIRECTED  = 20;
    localparam int N_PHASES    = 20;
    localparam int DEEP_PHASE  = 10;
    localparam int PHASE_BEATS = 100;
    localparam int DEEP_BEATS  = 6;

    localparam t_view_cfg VIEW_RST = '{etf_pkg::RST_ORIGIN_REAL, etf_pkg::RST_ORIGIN_IMAG,
                                       etf_pkg::RST_PIXEL_STEP, etf_pkg::RST_ITER_LIMIT, 1'b0};
    localparam t_view_cfg VIEW_NO_ITER = '{etf_pkg::RST_ORIGIN_REAL, etf_pkg::RST_ORIGIN_IMAG,
                                           etf_pkg::RST_PIXEL_STEP, 12'd0, 1'b0};
    localparam t_view_cfg VIEW_NO_ITER_SHIP = '{etf_pkg::RST_ORIGIN_REAL,
                                                etf_pkg::RST_ORIGIN_IMAG,
                                                etf_pkg::RST_PIXEL_STEP, 12'd0, 1'b1};
    localparam t_view_cfg VIEW_ONE_ITER = '{etf_pkg::RST_ORIGIN_REAL, etf_pkg::RST_ORIGIN_IMAG,
                                            etf_pkg::RST_PIXEL_STEP, 12'd1, 1'b0};
    localparam t_view_cfg VIEW_ORIGIN_ONLY = '{32'sd0, 32'sd0, 31'd0, 12'd30, 1'b0};
    // c = -2 exactly: |z|^2 lands on the escape threshold
    localparam t_view_cfg VIEW_ON_CIRCLE = '{-32'sd536870912, 32'sd0, 31'd0, 12'd30, 1'b0};
    localparam t_view_cfg VIEW_NEAR_CIRCLE = '{-32'sd536870911, 32'sd0, 31'd0, 12'd30, 1'b0};
    localparam t_view_cfg VIEW_SHIP_MIN = '{etf_pkg::MIN32, 32'sd0, 31'd0, 12'd30, 1'b1};
    localparam t_view_cfg VIEW_SHIP_RST = '{etf_pkg::RST_ORIGIN_REAL, etf_pkg::RST_ORIGIN_IMAG,
                                            etf_pkg::RST_PIXEL_STEP, etf_pkg::RST_ITER_LIMIT,
                                            1'b1};
    localparam t_view_cfg VIEW_TOP = '{etf_pkg::MAX32, etf_pkg::MAX32, 31'h7FFF_FFFF,
                                       12'hFFF, 1'b0};
    localparam t_view_cfg VIEW_BOTTOM = '{etf_pkg::MIN32, etf_pkg::MIN32, 31'd1, 12'hFFF, 1'b0};
    localparam t_view_cfg VIEW_DEEP = '{32'sd0, 32'sd0, 31'd1, 12'hFFF, 1'b0};
    localparam t_view_cfg VIEW_SHIP_WIDE = '{etf_pkg::MIN32, etf_pkg::MIN32, 31'h7FFF_FFFF,
                                             12'hFFF, 1'b1};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    etf_pkg::t_pixel                 i_pixel = '0;
    logic                            o_result_strobe;
    etf_pkg::t_result                o_result;
    logic                            i_cfg_we = 1'b0;
    logic [etf_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [etf_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    etf_pkg::t_result pending_results[$];
    etf_pkg::t_result oldest;
    t_view_cfg        active_view = VIEW_RST;
    t_pixel_case      directed_cases [N_DIRECTED];
    int               mismatch_count = 0;
    int               sender_idle_pct = 35;

    escape_time_fractal_iteration dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel        (i_pixel),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clamp32(longint v);
        if (v > etf_pkg::MAX32) return etf_pkg::MAX32;
        if (v < etf_pkg::MIN32) return etf_pkg::MIN32;
        return v;
    endfunction

    // Iterate z = z^2 + c (or its ship variant) from zero under the active view; count updates until escape or limit
    function automatic etf_pkg::t_result predict_escape(etf_pkg::t_pixel px);
        longint           cr, ci, zr, zi, nr, ni;
        logic [63:0]      mag;
        etf_pkg::t_result res;
        cr = clamp32(longint'(active_view.origin_r)
                     + longint'(px.pixel_col) * longint'(active_view.step));
        ci = clamp32(longint'(active_view.origin_i)
                     + longint'(px.pixel_row) * longint'(active_view.step));
        zr = 0;
        zi = 0;
        mag = '0;
        res = '0;
        while (mag < etf_pkg::ESCAPE_Q56 && res.iteration_count < active_view.limit) begin
            nr = clamp32(((zr * zr - zi * zi) >>> etf_pkg::FRAC_BITS) + cr);
            ni = clamp32(((zr * zi) >>> (etf_pkg::FRAC_BITS - 1)) + ci);
            // Fold both parts into the first quadrant for the ship variant
            if (active_view.ship) begin
                if (nr < 0) nr = clamp32(-nr);
                if (ni < 0) ni = clamp32(-ni);
            end
            zr = nr;
            zi = ni;
            res.iteration_count = res.iteration_count + 1'b1;
            mag = $unsigned(zr * zr) + $unsigned(zi * zi);
        end
        res.escaped = (mag >= etf_pkg::ESCAPE_Q56);
        return res;
    endfunction

    // Pick a view: mostly a window over the interesting region, sometimes any origin and step (limit up to 64)
    function automatic t_view_cfg random_view(bit deep);
        t_view_cfg v;
        if (!deep && $urandom_range(9) == 0) begin
            v.origin_r = $urandom;
            v.origin_i = $urandom;
            v.step     = etf_pkg::STEP_W'($urandom);
            v.limit    = etf_pkg::ITER_BITS'($urandom_range(64));
            v.ship     = 1'($urandom_range(1));
        end else begin
            v.origin_r = etf_pkg::COORD_W'($urandom_range(939524096)) - 32'sd671088640;
            v.origin_i = etf_pkg::COORD_W'($urandom_range(671088640)) - 32'sd536870912;
            v.step     = etf_pkg::STEP_W'($urandom_range(1, 262144));
            v.limit    = deep ? {etf_pkg::ITER_BITS{1'b1}}
                              : etf_pkg::ITER_BITS'($urandom_range(1, 64));
            v.ship     = 1'($urandom_range(1));
        end
        return v;
    endfunction

    task automatic write_reg(logic [etf_pkg::CFG_INDEX_W-1:0] idx,
                             logic [etf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Drain the block, then write every register plus one unused index
    task automatic load_view(t_view_cfg v);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        write_reg(etf_pkg::CFG_ORIGIN_REAL, v.origin_r);
        write_reg(etf_pkg::CFG_ORIGIN_IMAG, v.origin_i);
        write_reg(etf_pkg::CFG_PIXEL_STEP, {1'($urandom), v.step});
        write_reg(etf_pkg::CFG_ITER_LIMIT, {20'($urandom), v.limit});
        write_reg(etf_pkg::CFG_BURNING_SHIP, {31'($urandom), v.ship});
        write_reg(etf_pkg::CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED,
                                                       2**etf_pkg::CFG_INDEX_W - 1)),
                  $urandom);
        i_cfg_we <= 1'b0;
        active_view = v;
    endtask

    // Offer one pixel beat after a random gap; hold it until taken
    task automatic send_pixel(etf_pkg::t_pixel px, logic typed, etf_pkg::t_result want);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(typed ? want : predict_escape(px));
    endtask

    // Check each result beat against the oldest pending expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got count %0d escaped %0b",
                         $time, o_result.iteration_count, o_result.escaped);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_result.iteration_count !== oldest.iteration_count) begin
                    $display("%0t: iteration_count mismatch: expected %0d, got %0d",
                             $time, oldest.iteration_count, o_result.iteration_count);
                    mismatch_count++;
                end
                if (o_result.escaped !== oldest.escaped) begin
                    $display("%0t: escaped mismatch: expected %0b, got %0b",
                             $time, oldest.escaped, o_result.escaped);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_view_cfg view;
        int        beats;
        directed_cases = '{
            // Reset view: corner escapes at once, far corner saturates c
            '{VIEW_RST, '{12'd0, 12'd0}, 1'b1, '{12'd1, 1'b1}},
            '{VIEW_RST, '{12'd4095, 12'd4095}, 1'b1, '{12'd1, 1'b1}},
            '{VIEW_RST, '{12'd230, 12'd180}, 1'b0, '0},
            '{VIEW_RST, '{12'd0, 12'd4095}, 1'b0, '0},
            '{VIEW_RST, '{12'd4095, 12'd0}, 1'b0, '0},
            '{VIEW_RST, '{12'd100, 12'd90}, 1'b0, '0},
            // Zero limit: no update at all
            '{VIEW_NO_ITER, '{12'd123, 12'd456}, 1'b1, '{12'd0, 1'b0}},
            '{VIEW_NO_ITER_SHIP, '{12'd4095, 12'd4095}, 1'b1, '{12'd0, 1'b0}},
            // Limit of one: escape on the last allowed update, or stop at the limit
            '{VIEW_ONE_ITER, '{12'd0, 12'd0}, 1'b1, '{12'd1, 1'b1}},
            '{VIEW_ONE_ITER, '{12'd230, 12'd180}, 1'b1, '{12'd1, 1'b0}},
            // Zero step: every pixel maps to the origin
            '{VIEW_ORIGIN_ONLY, '{12'd4095, 12'd4095}, 1'b1, '{12'd30, 1'b0}},
            '{VIEW_ON_CIRCLE, '{12'd2049, 12'd77}, 1'b1, '{12'd1, 1'b1}},
            '{VIEW_NEAR_CIRCLE, '{12'd0, 12'd0}, 1'b0, '0},
            // Ship mode: absolute value of the most negative part saturates
            '{VIEW_SHIP_MIN, '{12'd0, 12'd0}, 1'b0, '0},
            '{VIEW_SHIP_RST, '{12'd230, 12'd180}, 1'b0, '0},
            '{VIEW_SHIP_RST, '{12'd150, 12'd120}, 1'b0, '0},
            // Register extremes
            '{VIEW_TOP, '{12'd4095, 12'd4095}, 1'b1, '{12'd1, 1'b1}},
            '{VIEW_BOTTOM, '{12'd0, 12'd0}, 1'b1, '{12'd1, 1'b1}},
            '{VIEW_DEEP, '{12'd0, 12'd0}, 1'b1, '{12'd4095, 1'b0}},
            '{VIEW_SHIP_WIDE, '{12'd4095, 12'd0}, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table, reloading the view only when it changes
        foreach (directed_cases[k]) begin
            if (directed_cases[k].view != active_view) load_view(directed_cases[k].view);
            send_pixel(directed_cases[k].px, directed_cases[k].typed, directed_cases[k].want);
        end

        // Random views, sender gaps changing by phase group (35%, then 67%, then none)
        for (int ph = 0; ph < N_PHASES; ph++) begin
            sender_idle_pct = (ph < 7) ? 35 : (ph < 14) ? 67 : 0;
            view = random_view(ph == DEEP_PHASE);
            load_view(view);
            beats = (ph == DEEP_PHASE) ? DEEP_BEATS : PHASE_BEATS;
            repeat (beats) begin
                send_pixel(etf_pkg::t_pixel'({12'($urandom), 12'($urandom)}), 1'b0, '0);
            end
        end

        // Drain and allow one full pixel time for any stray beat
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * active_view.limit + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
